// File: rtl/core/fxd_pkg.sv
// shared types, constants and sine table for the frequency translating fir decimator
`timescale 1ns / 1ps
package fxd_pkg;

  localparam int MAX_TAPS_DEF    = 64;
  localparam int MAX_DECIM_DEF   = 64;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QTR_LEN         = 1 << (SINE_TABLE_BITS - 2);
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIMATION = 2'd0,
    CFG_TAP_COUNT  = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_TAP    = 2'd1,
    MODE_RETUNE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_TAP,
    CMD_RETUNE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        emit;
    logic [5:0]  idx;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_MAC,
    B_DRAIN,
    B_ROT_MUL,
    B_ROT_SUM,
    B_RET_MUL,
    B_RET_ADD
  } back_state_t;

  typedef logic signed [15:0] qtab_t [0:QTR_LEN];

  // quarter wave built by a taylor series in q30, rounded to q1.15
  function automatic qtab_t build_qsine();
    qtab_t       tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      sum;
    longint      q;
    for (int r = 0; r <= QTR_LEN; r++) begin
      x   = (HALF_PI_Q30 * 64'(r)) >> (SINE_TABLE_BITS - 2);
      x2  = (x * x) >> 30;
      t   = x;
      sum = longint'(x);
      t   = ((t * x2) >> 30) / 64'd6;
      sum = sum - longint'(t);
      t   = ((t * x2) >> 30) / 64'd20;
      sum = sum + longint'(t);
      t   = ((t * x2) >> 30) / 64'd42;
      sum = sum - longint'(t);
      t   = ((t * x2) >> 30) / 64'd72;
      sum = sum + longint'(t);
      t   = ((t * x2) >> 30) / 64'd110;
      sum = sum - longint'(t);
      t   = ((t * x2) >> 30) / 64'd156;
      sum = sum + longint'(t);
      if (sum < 0) sum = 0;
      q = (sum + 16384) >>> 15;
      if (q > 32767) q = 32767;
      tab[r] = q[15:0];
    end
    return tab;
  endfunction

  localparam qtab_t QSINE = build_qsine();

  function automatic logic signed [15:0] sin_q15(input logic [31:0] ph);
    logic [SINE_TABLE_BITS-1:0] n;
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-3:0] r;
    logic [SINE_TABLE_BITS-2:0] ri;
    logic signed [15:0]         v;
    n    = ph[31 -: SINE_TABLE_BITS];
    quad = n[SINE_TABLE_BITS-1 -: 2];
    r    = n[SINE_TABLE_BITS-3:0];
    if (quad[0]) ri = (SINE_TABLE_BITS-1)'(QTR_LEN) - {1'b0, r};
    else         ri = {1'b0, r};
    v = QSINE[ri];
    return quad[1] ? -v : v;
  endfunction

  function automatic logic signed [15:0] cos_q15(input logic [31:0] ph);
    return sin_q15(ph + 32'h4000_0000);
  endfunction

endpackage

// File: rtl/core/fxd_if.sv
// stream interfaces for input items and result items
`timescale 1ns / 1ps
interface fxd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [15:0] in_i;
  logic signed [15:0] in_q;
  logic [5:0]         tap_index;
  logic signed [15:0] tap_value;
  logic signed [31:0] freq_step;
  modport source (output valid, mode, in_i, in_q, tap_index, tap_value, freq_step,
                  input ready);
  modport sink (input valid, mode, in_i, in_q, tap_index, tap_value, freq_step,
                output ready);
endinterface

interface fxd_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] out_i;
  logic signed [23:0] out_q;
  logic               out_saturated;
  modport source (output valid, out_i, out_q, out_saturated, input ready);
  modport sink (input valid, out_i, out_q, out_saturated, output ready);
endinterface

// File: rtl/core/freq_translating_fir_decimator.sv
// top level of the frequency translating fir decimator
// flow: a sample beat on a decimation slot passes the queue, then the back end states
//   B_MAC, B_DRAIN, B_ROT_MUL and B_ROT_SUM, which sets out valid as it loads the result
// back end: taps and other samples end in B_IDLE, retunes pass B_RET_MUL and B_RET_ADD;
//   an output sample busies it until loaded; the mac pipeline takes one tap per cycle
// reset: synchronous active low; a clearing pass over every address zeroes the delay line
//   and tap memories, input ready stays low meanwhile, config writes are taken at any time
`timescale 1ns / 1ps
module freq_translating_fir_decimator #(
  parameter int MAX_TAPS  = fxd_pkg::MAX_TAPS_DEF,
  parameter int MAX_DECIM = fxd_pkg::MAX_DECIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fxd_in_if.sink                           in_ch,
  fxd_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [fxd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fxd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import fxd_pkg::*;

  localparam int DW = $clog2(MAX_DECIM + 1);
  localparam int NW = $clog2(MAX_TAPS + 1);

  logic [6:0]    decimation_r, tap_count_r;
  logic [DW-1:0] decim_eff;
  logic [NW-1:0] taps_eff;
  logic          push, pop, q_empty, q_full;
  cmd_t          push_cmd, head;
  back_stat_t    stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decimation_r <= 7'd1;
      tap_count_r  <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DECIMATION: decimation_r <= cfg_wdata;
        CFG_TAP_COUNT:  tap_count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero acts as one, values above the maximum act as the maximum
  always_comb begin
    if (decimation_r == '0)             decim_eff = DW'(1);
    else if (32'(decimation_r) > MAX_DECIM) decim_eff = DW'(MAX_DECIM);
    else                                decim_eff = DW'(decimation_r);
    if (tap_count_r == '0)              taps_eff = NW'(1);
    else if (32'(tap_count_r) > MAX_TAPS)   taps_eff = NW'(MAX_TAPS);
    else                                taps_eff = NW'(tap_count_r);
  end

  fxd_front #(.MAX_TAPS(MAX_TAPS), .MAX_DECIM(MAX_DECIM)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .decim(decim_eff), .stat(stat),
    .q_full(q_full), .push(push), .push_cmd(push_cmd)
  );

  fxd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd), .pop(pop),
    .head(head), .empty(q_empty), .full(q_full)
  );

  fxd_back #(.MAX_TAPS(MAX_TAPS), .MAX_DECIM(MAX_DECIM)) u_back (
    .clk(clk), .rst_n(rst_n), .decim(decim_eff), .n_taps(taps_eff), .head(head),
    .q_empty(q_empty), .pop(pop), .stat(stat), .out_ch(out_ch)
  );
endmodule

// File: rtl/core/fxd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module fxd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/fxd_queue.sv
// two entry command queue between front and back
`timescale 1ns / 1ps
module fxd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fxd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output fxd_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import fxd_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: rtl/core/fxd_front.sv
// front end: accepts beats, classifies them and tracks the decimation slot
`timescale 1ns / 1ps
module fxd_front #(
  parameter int MAX_TAPS  = fxd_pkg::MAX_TAPS_DEF,
  parameter int MAX_DECIM = fxd_pkg::MAX_DECIM_DEF,
  localparam int DW = $clog2(MAX_DECIM + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  fxd_in_if.sink              in_ch,
  input  logic [DW-1:0]       decim,
  input  fxd_pkg::back_stat_t stat,
  input  logic                q_full,
  output logic                push,
  output fxd_pkg::cmd_t       push_cmd
);
  import fxd_pkg::*;

  logic [DW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   cnt_inc;
  logic          acc;

  assign in_ch.ready = !q_full && !stat.clearing;
  assign acc         = in_ch.valid && in_ch.ready;
  assign cnt_inc     = {1'b0, cnt_r} + 1'b1;

  always_comb begin
    push          = 1'b0;
    cnt_nxt       = cnt_r;
    push_cmd.kind = CMD_SAMPLE;
    push_cmd.emit = (cnt_r == '0);
    push_cmd.idx  = in_ch.tap_index;
    push_cmd.data = {in_ch.in_q, in_ch.in_i};
    if (acc) begin
      unique case (in_ch.mode)
        MODE_SAMPLE: begin
          push    = 1'b1;
          cnt_nxt = (cnt_inc >= {1'b0, decim}) ? '0 : cnt_inc[DW-1:0];
        end
        MODE_TAP: begin
          push_cmd.kind = CMD_TAP;
          push_cmd.data = {16'd0, in_ch.tap_value};
          push          = (32'(in_ch.tap_index) < MAX_TAPS);
        end
        MODE_RETUNE: begin
          push_cmd.kind = CMD_RETUNE;
          push_cmd.data = in_ch.freq_step;
          push          = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end
endmodule

// File: rtl/core/fxd_back.sv
// back end: delay line and tap memories, pipelined complex mac, rotator and retune
`timescale 1ns / 1ps
module fxd_back #(
  parameter int MAX_TAPS  = fxd_pkg::MAX_TAPS_DEF,
  parameter int MAX_DECIM = fxd_pkg::MAX_DECIM_DEF,
  localparam int DW = $clog2(MAX_DECIM + 1),
  localparam int NW = $clog2(MAX_TAPS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [DW-1:0]       decim,
  input  logic [NW-1:0]       n_taps,
  input  fxd_pkg::cmd_t       head,
  input  logic                q_empty,
  output logic                pop,
  output fxd_pkg::back_stat_t stat,
  fxd_out_if.source           out_ch
);
  import fxd_pkg::*;

  localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int ACCW = 34 + NW;
  localparam int YW   = ACCW - 15;
  localparam int MW   = YW + 16;
  localparam int PW   = 33 + NW + 1;

  back_state_t state_r, state_nxt;

  logic [AW-1:0] clr_r, wptr_r, rptr_r, pos;
  logic [NW-1:0] tap_cnt_r;
  logic [31:0]   ph_r, a0_ph_r, w_r, p_r, wd_r, ret_freq_r;
  logic [3:0]    v_r;

  logic          s_we, t_we;
  logic [AW-1:0] s_waddr, t_waddr;
  logic [31:0]   s_wdata, s_rdata;
  logic [15:0]   t_wdata, t_rdata;
  logic          load_out, out_free;

  logic signed [15:0]   h1_r, c1_r, sn1_r;
  logic [31:0]          x1_r, x2_r;
  logic signed [31:0]   prc, prs;
  logic signed [16:0]   cr2_r, ci2_r;
  logic signed [32:0]   pii_r, pqq_r, piq_r, pqi_r;
  logic signed [ACCW-1:0] acc_i_r, acc_q_r;
  logic signed [YW-1:0] yi, yq;
  logic signed [MW-1:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [MW:0]   si, sq;
  logic signed [MW-15:0] zi, zq;
  logic signed [23:0]   zi_sat, zq_sat;
  logic                 clip_i, clip_q;
  logic signed [32:0]   diff;
  logic signed [PW-1:0] ret_prod_r, ret_half;
  logic signed [15:0]   rc, rs;

  logic               out_valid_r;
  logic signed [23:0] out_i_r, out_q_r;
  logic               out_sat_r;

  assign pos           = (wptr_r == AW'(MAX_TAPS - 1)) ? '0 : wptr_r + 1'b1;
  assign out_free      = !out_valid_r || out_ch.ready;
  assign stat.clearing = (state_r == B_CLEAR);

  fxd_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_line (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(rptr_r), .rdata(s_rdata)
  );

  fxd_ram #(.WIDTH(16), .DEPTH(MAX_TAPS)) u_taps (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(tap_cnt_r[AW-1:0]), .rdata(t_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    s_we      = 1'b0;
    t_we      = 1'b0;
    s_waddr   = clr_r;
    t_waddr   = clr_r;
    s_wdata   = '0;
    t_wdata   = '0;
    load_out  = 1'b0;
    unique case (state_r)
      B_CLEAR: begin
        s_we = 1'b1;
        t_we = 1'b1;
        if (clr_r == AW'(MAX_TAPS - 1)) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head.kind)
            CMD_SAMPLE: begin
              s_we    = 1'b1;
              s_waddr = pos;
              s_wdata = head.data;
              if (head.emit) state_nxt = B_MAC;
            end
            CMD_TAP: begin
              t_we    = 1'b1;
              t_waddr = AW'(head.idx);
              t_wdata = head.data[15:0];
            end
            CMD_RETUNE: state_nxt = B_RET_MUL;
            default: ;
          endcase
        end
      end
      B_MAC:     if (tap_cnt_r == NW'(n_taps - 1'b1)) state_nxt = B_DRAIN;
      B_DRAIN:   if (v_r == '0) state_nxt = B_ROT_MUL;
      B_ROT_MUL: state_nxt = B_ROT_SUM;
      B_ROT_SUM: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      B_RET_MUL: state_nxt = B_RET_ADD;
      B_RET_ADD: state_nxt = B_IDLE;
      default:   state_nxt = B_IDLE;
    endcase
  end

  // mac and rotator arithmetic, floor shifts are arithmetic right shifts
  always_comb begin
    prc      = h1_r * c1_r;
    prs      = h1_r * sn1_r;
    yi       = acc_i_r[ACCW-1:15];
    yq       = acc_q_r[ACCW-1:15];
    rc       = cos_q15(p_r);
    rs       = sin_q15(p_r);
    si       = (MW+1)'(m1_r) - (MW+1)'(m2_r);
    sq       = (MW+1)'(m3_r) + (MW+1)'(m4_r);
    zi       = si[MW:15];
    zq       = sq[MW:15];
    clip_i   = (zi > (MW-14)'(8388607)) || (zi < -(MW-14)'(8388608));
    clip_q   = (zq > (MW-14)'(8388607)) || (zq < -(MW-14)'(8388608));
    zi_sat   = clip_i ? (zi[MW-15] ? 24'sh800000 : 24'sh7FFFFF) : zi[23:0];
    zq_sat   = clip_q ? (zq[MW-15] ? 24'sh800000 : 24'sh7FFFFF) : zq[23:0];
    diff     = $signed({ret_freq_r[31], ret_freq_r}) - $signed({w_r[31], w_r});
    ret_half = ret_prod_r >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      wptr_r      <= '0;
      w_r         <= '0;
      p_r         <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v_r     <= {v_r[2:0], state_r == B_MAC};
      if (state_r == B_CLEAR) clr_r <= clr_r + 1'b1;
      if (pop && head.kind == CMD_SAMPLE) wptr_r <= pos;
      if (state_r == B_RET_MUL) w_r <= ret_freq_r;
      if (state_r == B_RET_ADD) p_r <= p_r - ret_half[31:0];
      if (load_out) p_r <= p_r - wd_r;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rptr_r     <= pos;
      tap_cnt_r  <= '0;
      ph_r       <= '0;
      acc_i_r    <= '0;
      acc_q_r    <= '0;
      ret_freq_r <= head.data;
    end
    if (state_r == B_MAC) begin
      rptr_r    <= (rptr_r == '0) ? AW'(MAX_TAPS - 1) : rptr_r - 1'b1;
      tap_cnt_r <= tap_cnt_r + 1'b1;
      ph_r      <= ph_r + w_r;
    end
    a0_ph_r <= ph_r;
    // stage 1: memory data and composite tap rotation lookups
    h1_r  <= t_rdata;
    c1_r  <= cos_q15(a0_ph_r);
    sn1_r <= sin_q15(a0_ph_r);
    x1_r  <= s_rdata;
    // stage 2: composite tap
    cr2_r <= prc[31:15];
    ci2_r <= prs[31:15];
    x2_r  <= x1_r;
    // stage 3: complex products
    pii_r <= cr2_r * $signed(x2_r[15:0]);
    pqq_r <= ci2_r * $signed(x2_r[31:16]);
    piq_r <= cr2_r * $signed(x2_r[31:16]);
    pqi_r <= ci2_r * $signed(x2_r[15:0]);
    // stage 4: accumulate
    if (v_r[3]) begin
      acc_i_r <= acc_i_r + ACCW'(pii_r) - ACCW'(pqq_r);
      acc_q_r <= acc_q_r + ACCW'(piq_r) + ACCW'(pqi_r);
    end
    if (state_r == B_ROT_MUL) begin
      m1_r <= yi * rc;
      m2_r <= yq * rs;
      m3_r <= yi * rs;
      m4_r <= yq * rc;
      wd_r <= 32'(w_r * 32'(decim));
    end
    if (state_r == B_RET_MUL)
      ret_prod_r <= diff * $signed({1'b0, NW'(n_taps - 1'b1)});
    if (load_out) begin
      out_i_r   <= zi_sat;
      out_q_r   <= zq_sat;
      out_sat_r <= clip_i || clip_q;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_i         = out_i_r;
  assign out_ch.out_q         = out_q_r;
  assign out_ch.out_saturated = out_sat_r;

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CLEAR) |-> !pop) else $error("queue popped during clear");
  a_mac_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MAC) |=> v_r[0]) else $error("mac issue lost");
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROT_MUL) |-> (v_r == '0)) else $error("rotate before drain");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROT_SUM && !out_free) |=> (state_r == B_ROT_SUM))
    else $error("result dropped while output busy");
endmodule

// File: dv/tb_freq_translating_fir_decimator.sv
// self-checking testbench for the frequency translating fir decimator
`timescale 1ns / 1ps
module tb_freq_translating_fir_decimator;
  import fxd_pkg::*;

  typedef struct {
    mode_t            mode;
    logic [1:0]       raw_mode;
    logic signed [15:0] si;
    logic signed [15:0] sq;
    logic [5:0]       tidx;
    logic signed [15:0] tval;
    logic signed [31:0] fstep;
  } stim_t;

  typedef struct {
    logic signed [23:0] zi;
    logic signed [23:0] zq;
    logic               clip;
  } ddc_out_t;

  localparam int QLEN = 1 << (SINE_TABLE_BITS - 2);
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fxd_in_if  in_bus ();
  fxd_out_if out_bus ();

  freq_translating_fir_decimator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus.sink),
    .out_ch    (out_bus.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  int              qwave [0:QLEN];
  logic [31:0]     line_mem [0:63];
  logic signed [15:0] proto [0:63];
  logic [31:0]     center_w;
  logic [31:0]     rot_ph;
  int              slot_cnt;
  logic [6:0]      decim_reg;
  logic [6:0]      ntaps_reg;

  stim_t    pending_items [$];
  ddc_out_t awaited_results [$];
  int       mismatches;
  int       results_seen;
  logic     beat_taken;
  logic     hold_send;
  int       burst_left;
  int       gap_left;
  int       rx_mode_left;
  int       rx_stall_pct;
  int       long_left;
  logic     long_done;
  longint   cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void build_wave();
    longint unsigned x, x2, t;
    longint s, q;
    for (int r = 0; r <= QLEN; r++) begin
      x = (HALF_PI_Q30 * r) >> (SINE_TABLE_BITS - 2);
      x2 = (x * x) >> 30;
      t = x;
      s = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) s = s - longint'(t);
        else s = s + longint'(t);
      end
      if (s < 0) s = 0;
      q = (s + 16384) >>> 15;
      if (q > 32767) q = 32767;
      qwave[r] = int'(q);
    end
  endfunction

  function automatic longint wave_sin(logic [31:0] ph);
    logic [9:0] n;
    int v;
    n = ph[31:22];
    v = n[8] ? qwave[QLEN - n[7:0]] : qwave[n[7:0]];
    return n[9] ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint wave_cos(logic [31:0] ph);
    return wave_sin(ph + 32'h4000_0000);
  endfunction

  function automatic int clamp_reg(logic [6:0] v);
    if (v == 0) return 1;
    return (v > 64) ? 64 : int'(v);
  endfunction

  function automatic longint sat_24(longint v, inout logic clip);
    if (v > 8388607) begin
      clip = 1'b1;
      return 8388607;
    end
    if (v < -8388608) begin
      clip = 1'b1;
      return -8388608;
    end
    return v;
  endfunction

  // advance the model by one accepted beat
  task automatic ddc_step(stim_t it);
    int n, d;
    longint adj, acc_i, acc_q, h, cr, ci, xi, xq, yi, yq, c, s, zi, zq;
    logic [31:0] ph;
    logic clip;
    logic fire;
    ddc_out_t r;
    n = clamp_reg(ntaps_reg);
    d = clamp_reg(decim_reg);
    if (it.raw_mode == MODE_TAP) begin
      proto[it.tidx] = it.tval;
    end else if (it.raw_mode == MODE_RETUNE) begin
      adj = ((longint'(it.fstep) - longint'($signed(center_w))) * (n - 1)) >>> 1;
      rot_ph = rot_ph - adj[31:0];
      center_w = it.fstep;
    end else if (it.raw_mode == MODE_SAMPLE) begin
      fire = (slot_cnt == 0);
      for (int k = 63; k > 0; k--) line_mem[k] = line_mem[k-1];
      line_mem[0] = {it.sq, it.si};
      slot_cnt = (slot_cnt + 1 >= d) ? 0 : slot_cnt + 1;
      if (fire) begin
        acc_i = 0;
        acc_q = 0;
        for (int k = 0; k < n; k++) begin
          ph = center_w * k;
          h = proto[k];
          cr = (h * wave_cos(ph)) >>> 15;
          ci = (h * wave_sin(ph)) >>> 15;
          xi = $signed(line_mem[k][15:0]);
          xq = $signed(line_mem[k][31:16]);
          acc_i += cr * xi - ci * xq;
          acc_q += cr * xq + ci * xi;
        end
        yi = acc_i >>> 15;
        yq = acc_q >>> 15;
        c = wave_cos(rot_ph);
        s = wave_sin(rot_ph);
        clip = 1'b0;
        zi = sat_24((yi * c - yq * s) >>> 15, clip);
        zq = sat_24((yi * s + yq * c) >>> 15, clip);
        rot_ph = rot_ph - center_w * d;
        r.zi = zi[23:0];
        r.zq = zq[23:0];
        r.clip = clip;
        awaited_results.push_back(r);
      end
    end
  endtask

  // input beats and output checks at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    beat_taken <= in_bus.valid && in_bus.ready && rst_n;
    if (rst_n && in_bus.valid && in_bus.ready) begin
      ddc_step(pending_items[0]);
      void'(pending_items.pop_front());
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen <= results_seen + 1;
      if (awaited_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected beat: i=%0d q=%0d sat=%0b", out_bus.out_i, out_bus.out_q,
                   out_bus.out_saturated);
      end else begin
        if (out_bus.out_i !== awaited_results[0].zi || out_bus.out_q !== awaited_results[0].zq
            || out_bus.out_saturated !== awaited_results[0].clip) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: exp i=%0d q=%0d sat=%0b got i=%0d q=%0d sat=%0b",
                     awaited_results[0].zi, awaited_results[0].zq, awaited_results[0].clip,
                     out_bus.out_i, out_bus.out_q, out_bus.out_saturated);
        end
        void'(awaited_results.pop_front());
      end
    end
  end

  // sender: bursts with gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (in_bus.valid && !beat_taken) begin
      in_bus.valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      in_bus.valid <= 1'b0;
    end else if (pending_items.size() > 0 && !hold_send) begin
      in_bus.valid     <= 1'b1;
      in_bus.mode      <= pending_items[0].raw_mode;
      in_bus.in_i      <= pending_items[0].si;
      in_bus.in_q      <= pending_items[0].sq;
      in_bus.tap_index <= pending_items[0].tidx;
      in_bus.tap_value <= pending_items[0].tval;
      in_bus.freq_step <= pending_items[0].fstep;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left = burst_left - 1;
      end
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // receiver: stall pattern in stretches, plus one long hold-off
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode_left = $urandom_range(20, 200);
      case ($urandom_range(0, 3))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 20;
        2: rx_stall_pct = 50;
        default: rx_stall_pct = 85;
      endcase
    end else begin
      rx_mode_left = rx_mode_left - 1;
    end
    if (!long_done && results_seen >= 60) begin
      long_done = 1'b1;
      long_left = 800;
    end
    if (long_left > 0) begin
      long_left = long_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_freq_translating_fir_decimator: done, errors");
      $finish;
    end
  end

  function automatic stim_t make_item(logic [1:0] m, int a, int b, int ix, int tv, int fs);
    stim_t it;
    it.raw_mode = m;
    it.mode = mode_t'(m);
    it.si = a[15:0];
    it.sq = b[15:0];
    it.tidx = ix[5:0];
    it.tval = tv[15:0];
    it.fstep = fs;
    return it;
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic stim_t rand_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 74)
      return make_item(MODE_SAMPLE, rand_sample(), rand_sample(), $urandom, $urandom, $urandom);
    if (pick < 88)
      return make_item(MODE_TAP, $urandom, $urandom, $urandom_range(0, 63), rand_sample(),
                       $urandom);
    if (pick < 95)
      return make_item(MODE_RETUNE, $urandom, $urandom, $urandom, $urandom,
                       ($urandom_range(0, 1) == 0) ? int'($urandom) :
                       int'($signed(20'($urandom))));
    return make_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_bus.valid || awaited_results.size() != 0);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [6:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx == CFG_DECIMATION) decim_reg = v;
    else ntaps_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [6:0] d, logic [6:0] n, int count, bit do_pause);
    wait_idle();
    write_reg(CFG_DECIMATION, d);
    write_reg(CFG_TAP_COUNT, n);
    for (int k = 0; k < count; k++) pending_items.push_back(rand_item());
    if (do_pause) begin
      wait (pending_items.size() < count / 2);
      hold_send = 1'b1;
      wait (awaited_results.size() == 0);
      repeat (30) @(negedge clk);
      hold_send = 1'b0;
    end
  endtask

  initial begin
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_SAMPLE;
    in_bus.in_i = '0;
    in_bus.in_q = '0;
    in_bus.tap_index = '0;
    in_bus.tap_value = '0;
    in_bus.freq_step = '0;
    out_bus.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_DECIMATION;
    cfg_wdata = '0;
    rst_n = 1'b0;
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    beat_taken = 1'b0;
    hold_send = 1'b0;
    burst_left = 0;
    gap_left = 0;
    rx_mode_left = 0;
    rx_stall_pct = 0;
    long_left = 0;
    long_done = 1'b0;
    build_wave();
    for (int k = 0; k < 64; k++) begin
      line_mem[k] = '0;
      proto[k] = '0;
    end
    center_w = '0;
    rot_ph = '0;
    slot_cnt = 0;
    decim_reg = 7'd1;
    ntaps_reg = 7'd1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes of taps, samples and retunes, unknown mode
    write_reg(CFG_TAP_COUNT, 7'd64);
    pending_items.push_back(make_item(MODE_TAP, 0, 0, 0, 32767, 0));
    pending_items.push_back(make_item(MODE_TAP, 0, 0, 63, -32768, 0));
    pending_items.push_back(make_item(MODE_TAP, 0, 0, 1, -32768, 0));
    pending_items.push_back(make_item(MODE_TAP, 0, 0, 62, 32767, 0));
    pending_items.push_back(make_item(MODE_SAMPLE, 32767, -32768, 0, 0, 0));
    pending_items.push_back(make_item(MODE_SAMPLE, -32768, 32767, 63, -1, -1));
    pending_items.push_back(make_item(MODE_RETUNE, 0, 0, 0, 0, 32'h7fff_ffff));
    pending_items.push_back(make_item(MODE_SAMPLE, -32768, -32768, 0, 0, 0));
    pending_items.push_back(make_item(MODE_RETUNE, 0, 0, 0, 0, 32'h8000_0000));
    pending_items.push_back(make_item(MODE_SAMPLE, 32767, 32767, 0, 0, 0));
    pending_items.push_back(make_item(2'd3, -1, -1, 63, -1, -1));
    pending_items.push_back(make_item(MODE_SAMPLE, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_RETUNE, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(MODE_SAMPLE, 1, -1, 0, 0, 0));

    // config phases; the second lowers the decimation while the slot counter sits high
    run_phase(7'd9, 7'd8, 7, 1'b0);
    run_phase(7'd3, 7'd8, 120, 1'b0);
    run_phase(7'd1, 7'd1, 250, 1'b1);
    run_phase(7'd0, 7'd0, 100, 1'b0);
    run_phase(7'd64, 7'd5, 250, 1'b0);
    run_phase(7'd127, 7'd127, 150, 1'b0);
    run_phase(7'd2, 7'd64, 200, 1'b0);
    run_phase(7'd4, 7'd16, 300, 1'b0);
    run_phase(7'd1, 7'd33, 200, 1'b0);
    run_phase(7'd6, 7'd3, 300, 1'b0);
    run_phase(7'd65, 7'd65, 60, 1'b0);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_freq_translating_fir_decimator: done, clean");
    end else begin
      $display("tb_freq_translating_fir_decimator: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/fxd_pkg.sv
rtl/core/fxd_if.sv
rtl/core/fxd_ram.sv
rtl/core/fxd_queue.sv
rtl/core/fxd_front.sv
rtl/core/fxd_back.sv
rtl/core/freq_translating_fir_decimator.sv
dv/tb_freq_translating_fir_decimator.sv
